[rtl/grc_pkg.sv]
// ----------------------------------------------------------------------------
// grc_pkg
// Shared constants, widths and the arctangent table of the grid ray caster.
// ----------------------------------------------------------------------------
`default_nettype none

package grc_pkg;

  // One tile is 64 pixels with 8 fraction bits, so 2^14 position units.
  localparam int TILE_LOG     = 14;
  localparam int MAP_COL_BITS = 5;
  localparam int MAP_ROW_BITS = 4;
  localparam int MAP_ADDR_W   = MAP_COL_BITS + MAP_ROW_BITS;
  localparam int MAP_DEPTH    = 1 << MAP_ADDR_W;
  localparam int XW           = 19;
  localparam int YW           = 18;
  localparam int ANGLE_W      = 16;
  localparam int COL_TAG_W    = 10;
  localparam int DIST_W       = 20;

  // Walk coordinates are signed and wide enough for a clamped intercept.
  localparam int POS_W  = 26;
  localparam int QUO_W  = 22;
  localparam int NUM_W  = 47;
  localparam int DEN_W  = 32;
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 20;
  localparam int SQ_IN_W = 41;
  localparam int ROOT_W  = 21;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_CNT_W = 5;
  localparam int VEC_W        = 32;
  localparam int ZW           = 34;
  localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [VEC_W-1:0] UNIT_VEC    = 32'sd1073741824;

  localparam logic signed [POS_W-1:0] TQ = 26'sd16384;
  localparam logic signed [POS_W-1:0] WQ = 26'sd524288;
  localparam logic signed [POS_W-1:0] HQ = 26'sd262144;

  localparam logic [1:0] KIND_EMPTY = 2'd3;
  localparam logic [2:0] KIND_OOB   = 3'd4;
  localparam logic [2:0] KIND_NONE  = 3'd3;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  localparam logic REG_VIEWER_X = 1'b0;
  localparam logic REG_VIEWER_Y = 1'b1;

  // Handshake of one iterative unit.
  typedef struct packed {
    logic start;
  } unit_req_t;

  // Arctangent of 2^-i in a 32-bit binary angle.
  function automatic logic [29:0] arc_angle(input logic [CORDIC_CNT_W-1:0] idx);
    logic [29:0] a;
    unique case (idx)
      5'd0:  a = 30'd536870912;
      5'd1:  a = 30'd316933406;
      5'd2:  a = 30'd167458907;
      5'd3:  a = 30'd85004756;
      5'd4:  a = 30'd42667331;
      5'd5:  a = 30'd21354465;
      5'd6:  a = 30'd10679838;
      5'd7:  a = 30'd5340245;
      5'd8:  a = 30'd2670163;
      5'd9:  a = 30'd1335087;
      5'd10: a = 30'd667544;
      5'd11: a = 30'd333772;
      5'd12: a = 30'd166886;
      5'd13: a = 30'd83443;
      5'd14: a = 30'd41722;
      5'd15: a = 30'd20861;
      5'd16: a = 30'd10430;
      5'd17: a = 30'd5215;
      5'd18: a = 30'd2608;
      5'd19: a = 30'd1304;
      5'd20: a = 30'd652;
      5'd21: a = 30'd326;
      5'd22: a = 30'd163;
      5'd23: a = 30'd81;
      5'd24: a = 30'd41;
      5'd25: a = 30'd20;
      5'd26: a = 30'd10;
      5'd27: a = 30'd5;
      5'd28: a = 30'd3;
      5'd29: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

[rtl/grc_cordic.sv]
// ----------------------------------------------------------------------------
// grc_cordic
// Iterative CORDIC rotator: one micro-rotation per cycle gives cos and sin.
// ----------------------------------------------------------------------------
`default_nettype none

module grc_cordic (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire grc_pkg::unit_req_t                  req,
  input  wire logic [grc_pkg::ANGLE_W-1:0]         angle,
  output logic                                     done,
  output logic signed [grc_pkg::VEC_W-1:0]         cos_o,
  output logic signed [grc_pkg::VEC_W-1:0]         sin_o
);

  logic                                    busy_r;
  logic                                    done_r;
  logic [grc_pkg::CORDIC_CNT_W-1:0]        cnt_r;
  logic signed [grc_pkg::VEC_W-1:0]        x_r;
  logic signed [grc_pkg::VEC_W-1:0]        y_r;
  logic signed [grc_pkg::ZW-1:0]           z_r;
  logic [1:0]                              q_r;

  logic [grc_pkg::ANGLE_W-1:0]             shifted;
  logic [1:0]                              q_in;
  logic [grc_pkg::ANGLE_W-1:0]             r_in;
  logic signed [grc_pkg::ZW-1:0]           z_in;
  logic signed [grc_pkg::VEC_W-1:0]        dx;
  logic signed [grc_pkg::VEC_W-1:0]        dy;
  logic signed [grc_pkg::ZW-1:0]           arc;

  // Quadrant fold of the start angle.
  always_comb begin
    shifted = angle + 16'h2000;
    q_in    = shifted[grc_pkg::ANGLE_W-1 -: 2];
    r_in    = angle - {q_in, 14'd0};
    z_in    = grc_pkg::ZW'($signed({r_in, 16'd0}));
  end

  // Micro-rotation terms.
  always_comb begin
    dx  = y_r >>> cnt_r;
    dy  = x_r >>> cnt_r;
    arc = grc_pkg::ZW'($signed({1'b0, grc_pkg::arc_angle(cnt_r)}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        q_r   <= q_in;
        z_r   <= z_in;
        y_r   <= '0;
        cnt_r <= '0;
        if (z_in == '0) begin
          x_r    <= grc_pkg::UNIT_VEC;
          done_r <= 1'b1;
        end else begin
          x_r    <= grc_pkg::CORDIC_GAIN;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (!z_r[grc_pkg::ZW-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - arc;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + arc;
        end
        if (cnt_r == grc_pkg::CORDIC_CNT_W'(grc_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // Rotate the folded vector, within 45 degrees of the x axis, back into its quadrant.
  always_comb begin
    unique case (q_r)
      2'd0: begin cos_o = x_r;  sin_o = y_r;  end
      2'd1: begin cos_o = -y_r; sin_o = x_r;  end
      2'd2: begin cos_o = -x_r; sin_o = -y_r; end
      default: begin cos_o = y_r; sin_o = -x_r; end
    endcase
  end

  assign done = done_r;

endmodule

`default_nettype wire

[rtl/grc_divider.sv]
// ----------------------------------------------------------------------------
// grc_divider
// Restoring divider, one quotient bit per cycle, quotient clamped to all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module grc_divider (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire grc_pkg::unit_req_t                req,
  input  wire logic [grc_pkg::NUM_W-1:0]         num,
  input  wire logic [grc_pkg::DEN_W-1:0]         den,
  output logic                                   done,
  output logic [grc_pkg::QUO_W-1:0]              quo
);

  localparam int HI_W  = grc_pkg::NUM_W - grc_pkg::QUO_W;
  localparam int CNT_W = $clog2(grc_pkg::QUO_W);

  logic                              busy_r;
  logic                              done_r;
  logic [CNT_W-1:0]                  cnt_r;
  logic [grc_pkg::DEN_W-1:0]         rem_r;
  logic [grc_pkg::QUO_W-1:0]         low_r;
  logic [grc_pkg::QUO_W-1:0]         quo_r;
  logic [grc_pkg::DEN_W-1:0]         den_r;

  logic [HI_W-1:0]                   hi;
  logic                              ovf;
  logic [grc_pkg::DEN_W:0]           trial;
  logic                              fits;

  // A quotient that needs more bits than kept is clamped; the caller only
  // needs to know that it lands off the map.
  always_comb begin
    hi    = num[grc_pkg::NUM_W-1 -: HI_W];
    ovf   = grc_pkg::DEN_W'(hi) >= den;
    trial = {rem_r, low_r[grc_pkg::QUO_W-1]};
    fits  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        den_r <= den;
        cnt_r <= '0;
        if (ovf) begin
          quo_r  <= '1;
          done_r <= 1'b1;
        end else begin
          rem_r  <= grc_pkg::DEN_W'(hi);
          low_r  <= num[grc_pkg::QUO_W-1:0];
          quo_r  <= '0;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= grc_pkg::DEN_W'(trial - {1'b0, den_r});
        end else begin
          rem_r <= trial[grc_pkg::DEN_W-1:0];
        end
        low_r <= {low_r[grc_pkg::QUO_W-2:0], 1'b0};
        quo_r <= {quo_r[grc_pkg::QUO_W-2:0], fits};
        if (cnt_r == CNT_W'(grc_pkg::QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

[rtl/grc_isqrt.sv]
// ----------------------------------------------------------------------------
// grc_isqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module grc_isqrt (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire grc_pkg::unit_req_t                req,
  input  wire logic [grc_pkg::SQ_IN_W-1:0]       val,
  output logic                                   done,
  output logic [grc_pkg::ROOT_W-1:0]             root
);

  localparam int RW    = grc_pkg::SQ_IN_W + 1;
  localparam int CNT_W = $clog2(grc_pkg::ROOT_W);

  logic                          busy_r;
  logic                          done_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [grc_pkg::SQ_IN_W-1:0]   v_r;
  logic [RW-1:0]                 root_r;
  logic [RW-1:0]                 bit_r;
  logic [RW-1:0]                 sum;

  assign sum = root_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        v_r    <= val;
        root_r <= '0;
        bit_r  <= RW'(1) << (2 * (grc_pkg::ROOT_W - 1));
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if ({1'b0, v_r} >= sum) begin
          v_r    <= grc_pkg::SQ_IN_W'({1'b0, v_r} - sum);
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (cnt_r == CNT_W'(grc_pkg::ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r[grc_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

[rtl/grid_ray_caster_unit.sv]
// A cast takes longer for every further grid crossing that a walk steps through;
// an axis angle or a clamped quotient shortens it.
// Throughput: one item at a time; the next item is taken the cycle after the result
// is loaded. The CORDIC, the serial divider and the square root set the cast time.
// Reset: synchronous active-low; clears the sequencer, output valid and viewer.
// ----------------------------------------------------------------------------
// grid_ray_caster_unit
// Stores tile items in a tile map; casts one ray over it and returns the nearest grid crossing hit.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_ray_caster_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_index,
  input  wire logic [grc_pkg::XW-1:0]              cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_action,
  input  wire logic [grc_pkg::MAP_ROW_BITS-1:0]    in_tile_row,
  input  wire logic [grc_pkg::MAP_COL_BITS-1:0]    in_tile_col,
  input  wire logic [1:0]                          in_tile_kind,
  input  wire logic [grc_pkg::ANGLE_W-1:0]         in_ray_angle,
  input  wire logic [grc_pkg::COL_TAG_W-1:0]       in_column,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [grc_pkg::COL_TAG_W-1:0]            out_column,
  output logic [grc_pkg::DIST_W-1:0]               out_distance,
  output logic [grc_pkg::XW-1:0]                   out_hit_x,
  output logic [grc_pkg::YW-1:0]                   out_hit_y,
  output logic                                     out_hit_vertical,
  output logic [2:0]                               out_hit_kind
);

  localparam int P = grc_pkg::POS_W;
  localparam int T = grc_pkg::TILE_LOG;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CORDIC    = 4'd1;
  localparam logic [3:0] S_SETUP     = 4'd2;
  localparam logic [3:0] S_MUL       = 4'd3;
  localparam logic [3:0] S_DIV_OFF   = 4'd4;
  localparam logic [3:0] S_WAIT_OFF  = 4'd5;
  localparam logic [3:0] S_DIV_STEP  = 4'd6;
  localparam logic [3:0] S_WAIT_STEP = 4'd7;
  localparam logic [3:0] S_WALK_A    = 4'd8;
  localparam logic [3:0] S_WALK_B    = 4'd9;
  localparam logic [3:0] S_SQ_X      = 4'd10;
  localparam logic [3:0] S_SQ_Y      = 4'd11;
  localparam logic [3:0] S_SQ_SUM    = 4'd12;
  localparam logic [3:0] S_SQRT      = 4'd13;
  localparam logic [3:0] S_NEXT      = 4'd14;
  localparam logic [3:0] S_OUT       = 4'd15;

  // Configuration and item registers.
  logic [grc_pkg::XW-1:0]          px_r;
  logic [grc_pkg::YW-1:0]          py_r;
  logic [3:0]                      state_r;
  logic [3:0]                      state_nxt;
  logic [grc_pkg::COL_TAG_W-1:0]   tag_r;
  logic                            up_r;
  logic                            right_r;
  logic                            dir_r;
  logic [grc_pkg::DEN_W-1:0]       ac_r;
  logic [grc_pkg::DEN_W-1:0]       as_r;
  logic signed [P-1:0]             coord_r;
  logic [grc_pkg::QUO_W-1:0]       off_q_r;

  // Shared multiplier.
  logic [grc_pkg::MUL_A_W-1:0]     mul_a_r;
  logic [grc_pkg::MUL_B_W-1:0]     mul_b_r;
  logic [grc_pkg::MUL_A_W+grc_pkg::MUL_B_W-1:0] prod_r;
  logic [39:0]                     sqx_r;

  // Walk state.
  logic signed [P-1:0]             wx_r;
  logic signed [P-1:0]             wy_r;
  logic signed [P-1:0]             sx_r;
  logic signed [P-1:0]             sy_r;
  logic                            offx_r;
  logic                            offy_r;
  logic                            oob_r;

  // Per-direction hit record; index 0 is the horizontal walk.
  logic                            found_r [2];
  logic [grc_pkg::XW:0]            hx_r    [2];
  logic [grc_pkg::YW:0]            hy_r    [2];
  logic [2:0]                      kind_r  [2];
  logic [grc_pkg::ROOT_W-1:0]      dist_r  [2];

  // Tile map.
  logic [1:0]                      tile_mem [grc_pkg::MAP_DEPTH];
  logic [1:0]                      mem_q_r;
  logic [grc_pkg::MAP_ADDR_W-1:0]  rd_addr;

  logic                            out_valid_r;
  logic                            in_acc;
  logic                            out_free;

  logic signed [grc_pkg::VEC_W-1:0] cos_w;
  logic signed [grc_pkg::VEC_W-1:0] sin_w;
  logic                             cordic_done;
  logic                             div_done;
  logic [grc_pkg::QUO_W-1:0]        div_quo;
  logic                             sqrt_done;
  logic [grc_pkg::ROOT_W-1:0]       sqrt_root;
  grc_pkg::unit_req_t               cordic_req;
  grc_pkg::unit_req_t               div_req;
  grc_pkg::unit_req_t               sqrt_req;
  logic [grc_pkg::NUM_W-1:0]        div_num;

  logic [grc_pkg::DEN_W-1:0]        den_sel;
  logic [grc_pkg::DEN_W-1:0]        m_sel;
  logic [T:0]                       off_sel;
  logic signed [P-1:0]              coord_sel;
  logic signed [P-1:0]              px_s;
  logic signed [P-1:0]              py_s;
  logic signed [P-1:0]              q_s;
  logic signed [P-1:0]              pxp;
  logic signed [P-1:0]              pyp;
  logic                             in_range;
  logic                             probe_oob;
  logic [2:0]                       kind_now;
  logic signed [P-1:0]              ddx;
  logic signed [P-1:0]              ddy;
  logic [grc_pkg::MUL_B_W-1:0]      adx;
  logic [grc_pkg::MUL_B_W-1:0]      ady;
  logic                             h_less;
  logic                             vsel;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Iterative units.
  assign cordic_req.start = (state_r == S_IDLE) && in_acc && (in_action == grc_pkg::ACT_CAST);
  assign div_req.start    = (state_r == S_DIV_OFF) || (state_r == S_DIV_STEP);
  assign sqrt_req.start   = (state_r == S_SQ_SUM);
  assign div_num = (state_r == S_DIV_OFF) ? prod_r[grc_pkg::NUM_W-1:0]
                                          : grc_pkg::NUM_W'({m_sel, {T{1'b0}}});

  grc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cordic_req),
    .angle (in_ray_angle),
    .done  (cordic_done),
    .cos_o (cos_w),
    .sin_o (sin_w)
  );

  grc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .num   (div_num),
    .den   (den_sel),
    .done  (div_done),
    .quo   (div_quo)
  );

  grc_isqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .val   ({1'b0, sqx_r} + grc_pkg::SQ_IN_W'(prod_r[39:0])),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // Direction-dependent setup terms: the ratio numerator, its divisor, the
  // distance to the first grid line and that line's position.
  always_comb begin
    px_s = P'(px_r);
    py_s = P'(py_r);
    q_s  = P'(off_q_r);
    if (!dir_r) begin
      den_sel   = as_r;
      m_sel     = ac_r;
      off_sel   = up_r ? {1'b0, py_r[T-1:0]} : ((T+1)'(1) << T) - {1'b0, py_r[T-1:0]};
      coord_sel = P'({py_r[grc_pkg::YW-1:T], {T{1'b0}}}) + (up_r ? P'(0) : grc_pkg::TQ);
    end else begin
      den_sel   = ac_r;
      m_sel     = as_r;
      off_sel   = right_r ? ((T+1)'(1) << T) - {1'b0, px_r[T-1:0]} : {1'b0, px_r[T-1:0]};
      coord_sel = P'({px_r[grc_pkg::XW-1:T], {T{1'b0}}}) + (right_r ? grc_pkg::TQ : P'(0));
    end
  end

  // Probe point and bounds of the current walk position.
  always_comb begin
    pxp       = wx_r - P'(offx_r);
    pyp       = wy_r - P'(offy_r);
    in_range  = !wx_r[P-1] && (wx_r <= grc_pkg::WQ) && !wy_r[P-1] && (wy_r <= grc_pkg::HQ);
    probe_oob = pxp[P-1] || pyp[P-1] || (pxp >= grc_pkg::WQ) || (pyp >= grc_pkg::HQ);
    rd_addr   = {pyp[T+grc_pkg::MAP_ROW_BITS-1:T], pxp[T+grc_pkg::MAP_COL_BITS-1:T]};
    kind_now  = oob_r ? grc_pkg::KIND_OOB : {1'b0, mem_q_r};
    ddx       = wx_r - px_s;
    ddy       = wy_r - py_s;
    adx       = ddx[P-1] ? grc_pkg::MUL_B_W'(-ddx) : ddx[grc_pkg::MUL_B_W-1:0];
    ady       = ddy[P-1] ? grc_pkg::MUL_B_W'(-ddy) : ddy[grc_pkg::MUL_B_W-1:0];
  end

  // Tile map: written by tile items, read at the probe point of the current walk position.
  always_ff @(posedge clk) begin
    if (in_acc && (in_action == grc_pkg::ACT_WRITE)) begin
      tile_mem[{in_tile_row, in_tile_col}] <= in_tile_kind;
    end
    mem_q_r <= tile_mem[rd_addr];
  end

  // Shared multiplier with registered operands and product.
  always_ff @(posedge clk) begin
    prod_r <= mul_a_r * mul_b_r;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
      py_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == grc_pkg::REG_VIEWER_X) begin
        px_r <= cfg_data;
      end else begin
        py_r <= cfg_data[grc_pkg::YW-1:0];
      end
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_acc && (in_action == grc_pkg::ACT_CAST)) state_nxt = S_CORDIC;
      S_CORDIC:    if (cordic_done) state_nxt = S_SETUP;
      S_SETUP:     state_nxt = (den_sel == '0) ? S_NEXT : S_MUL;
      S_MUL:       state_nxt = S_DIV_OFF;
      S_DIV_OFF:   state_nxt = S_WAIT_OFF;
      S_WAIT_OFF:  if (div_done) state_nxt = S_DIV_STEP;
      S_DIV_STEP:  state_nxt = S_WAIT_STEP;
      S_WAIT_STEP: if (div_done) state_nxt = S_WALK_A;
      S_WALK_A:    state_nxt = in_range ? S_WALK_B : S_NEXT;
      S_WALK_B:    state_nxt = (kind_now != grc_pkg::KIND_NONE) ? S_SQ_X : S_WALK_A;
      S_SQ_X:      state_nxt = S_SQ_Y;
      S_SQ_Y:      state_nxt = S_SQ_SUM;
      S_SQ_SUM:    state_nxt = S_SQRT;
      S_SQRT:      if (sqrt_done) state_nxt = S_NEXT;
      S_NEXT:      state_nxt = dir_r ? S_OUT : S_SETUP;
      S_OUT:       if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers of the cast.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        tag_r   <= in_column;
        up_r    <= in_ray_angle > 16'h8000;
        right_r <= (in_ray_angle < 16'h4000) || (in_ray_angle > 16'hC000);
        dir_r   <= 1'b0;
      end
      S_CORDIC: begin
        ac_r <= cos_w[grc_pkg::VEC_W-1] ? grc_pkg::DEN_W'(-cos_w) : grc_pkg::DEN_W'(cos_w);
        as_r <= sin_w[grc_pkg::VEC_W-1] ? grc_pkg::DEN_W'(-sin_w) : grc_pkg::DEN_W'(sin_w);
      end
      S_SETUP: begin
        coord_r        <= coord_sel;
        mul_a_r        <= m_sel;
        mul_b_r        <= grc_pkg::MUL_B_W'(off_sel);
        found_r[dir_r] <= 1'b0;
        hx_r[dir_r]    <= '0;
        hy_r[dir_r]    <= '0;
        kind_r[dir_r]  <= grc_pkg::KIND_OOB;
      end
      S_WAIT_OFF: begin
        if (div_done) off_q_r <= div_quo;
      end
      S_WAIT_STEP: begin
        if (!dir_r) begin
          wx_r   <= right_r ? px_s + q_s : px_s - q_s;
          wy_r   <= coord_r;
          sx_r   <= right_r ? P'(div_quo) : -P'(div_quo);
          sy_r   <= up_r ? -grc_pkg::TQ : grc_pkg::TQ;
          offx_r <= 1'b0;
          offy_r <= up_r;
        end else begin
          wx_r   <= coord_r;
          wy_r   <= up_r ? py_s - q_s : py_s + q_s;
          sx_r   <= right_r ? grc_pkg::TQ : -grc_pkg::TQ;
          sy_r   <= up_r ? -P'(div_quo) : P'(div_quo);
          offx_r <= !right_r;
          offy_r <= 1'b0;
        end
      end
      S_WALK_A: begin
        oob_r <= probe_oob;
      end
      S_WALK_B: begin
        if (kind_now != grc_pkg::KIND_NONE) begin
          found_r[dir_r] <= 1'b1;
          hx_r[dir_r]    <= wx_r[grc_pkg::XW:0];
          hy_r[dir_r]    <= wy_r[grc_pkg::YW:0];
          kind_r[dir_r]  <= kind_now;
          mul_a_r        <= grc_pkg::MUL_A_W'(adx);
          mul_b_r        <= adx;
        end else begin
          wx_r <= wx_r + sx_r;
          wy_r <= wy_r + sy_r;
        end
      end
      S_SQ_X: begin
        mul_a_r <= grc_pkg::MUL_A_W'(ady);
        mul_b_r <= ady;
      end
      S_SQ_Y: begin
        sqx_r <= prod_r[39:0];
      end
      S_SQRT: begin
        if (sqrt_done) dist_r[dir_r] <= sqrt_root;
      end
      S_NEXT: begin
        dir_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Nearer hit; a tie goes to the vertical walk.
  always_comb begin
    h_less = found_r[0] && (!found_r[1] || (dist_r[0] < dist_r[1]));
    vsel   = !h_less;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r      <= 1'b1;
        out_column       <= tag_r;
        out_hit_vertical <= vsel;
        out_hit_kind     <= kind_r[vsel];
        if (!found_r[vsel] || dist_r[vsel][grc_pkg::ROOT_W-1]) begin
          out_distance <= '1;
        end else begin
          out_distance <= dist_r[vsel][grc_pkg::DIST_W-1:0];
        end
        out_hit_x <= hx_r[vsel][grc_pkg::XW] ? '1 : hx_r[vsel][grc_pkg::XW-1:0];
        out_hit_y <= hy_r[vsel][grc_pkg::YW] ? '1 : hy_r[vsel][grc_pkg::YW-1:0];
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[rtl/grc_checker.sv]
// ----------------------------------------------------------------------------
// grc_checker
// Port-level checks of the grid ray caster, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module grc_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic                                in_action,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic [grc_pkg::DIST_W-1:0]          out_distance,
  input wire logic [grc_pkg::XW-1:0]              out_hit_x,
  input wire logic [grc_pkg::YW-1:0]              out_hit_y,
  input wire logic                                out_hit_vertical,
  input wire logic [2:0]                          out_hit_kind
);

  // No item is shown in the cycle after reset.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // An accepted cast keeps the block busy in the next cycle.
  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == grc_pkg::ACT_CAST |=> in_stall)
    else $error("cast accepted but block not busy");

  // A saturated distance means no hit, reported as vertical at the origin.
  a_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_distance == '1) |->
      out_hit_vertical && (out_hit_x == '0) && (out_hit_y == '0) &&
      (out_hit_kind == grc_pkg::KIND_OOB))
    else $error("no-hit result malformed");

endmodule

bind grid_ray_caster_unit grc_checker u_grc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_action        (in_action),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_distance     (out_distance),
  .out_hit_x        (out_hit_x),
  .out_hit_y        (out_hit_y),
  .out_hit_vertical (out_hit_vertical),
  .out_hit_kind     (out_hit_kind)
);

`default_nettype wire
